// ----- rtl/owtd_pkg.sv -----
// ----------------------------------------------------------------------------
// owtd_pkg: shared constants, codes and functions of the 1-Wire EEPROM decoder
// Event and result codes, phase codes, command bytes and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package owtd_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_ROM   = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // Result kinds
  localparam logic [3:0] KIND_RESET   = 4'd0;
  localparam logic [3:0] KIND_ROM     = 4'd1;
  localparam logic [3:0] KIND_COMMAND = 4'd2;
  localparam logic [3:0] KIND_ADDRESS = 4'd3;
  localparam logic [3:0] KIND_DATA    = 4'd4;
  localparam logic [3:0] KIND_ES      = 4'd5;
  localparam logic [3:0] KIND_CRC     = 4'd6;
  localparam logic [3:0] KIND_AUTH    = 4'd7;
  localparam logic [3:0] KIND_MAC     = 4'd8;
  localparam logic [3:0] KIND_STATUS  = 4'd9;
  localparam logic [3:0] KIND_WARNING = 4'd10;

  // Result subtypes
  localparam logic [1:0] DET_NONE        = 2'd0;
  localparam logic [1:0] DET_ROM_FIRST   = 2'd0;
  localparam logic [1:0] DET_ROM_SECOND  = 2'd1;
  localparam logic [1:0] DET_ROM_UNKNOWN = 2'd2;
  localparam logic [1:0] DET_DATA_SINGLE = 2'd0;
  localparam logic [1:0] DET_DATA_BLOCK  = 2'd1;
  localparam logic [1:0] DET_DATA_PAD    = 2'd2;
  localparam logic [1:0] DET_CRC_FRAME   = 2'd0;
  localparam logic [1:0] DET_CRC_MAC     = 2'd1;
  localparam logic [1:0] DET_ST_SUCCESS  = 2'd0;
  localparam logic [1:0] DET_ST_FAIL     = 2'd1;
  localparam logic [1:0] DET_ST_END      = 2'd2;
  localparam logic [1:0] DET_ST_DONE     = 2'd3;

  // Decoder phases
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_CMD  = 4'd1;
  localparam logic [3:0] PH_WSP  = 4'd2;
  localparam logic [3:0] PH_RSP  = 4'd3;
  localparam logic [3:0] PH_CSP  = 4'd4;
  localparam logic [3:0] PH_RMEM = 4'd5;
  localparam logic [3:0] PH_LFS  = 4'd6;
  localparam logic [3:0] PH_CNS  = 4'd7;
  localparam logic [3:0] PH_RAP  = 4'd8;

  // Family codes
  localparam logic [7:0] FAMILY_FIRST  = 8'h33;
  localparam logic [7:0] FAMILY_SECOND = 8'h23;

  // Function command bytes
  localparam logic [7:0] OP_WRITE_SP  = 8'h0F;
  localparam logic [7:0] OP_READ_SP   = 8'hAA;
  localparam logic [7:0] OP_COPY_SP   = 8'h55;
  localparam logic [7:0] OP_READ_MEM  = 8'hF0;
  localparam logic [7:0] OP_LOAD_SEC  = 8'h5A;
  localparam logic [7:0] OP_COMP_SEC  = 8'h33;
  localparam logic [7:0] OP_READ_PAGE = 8'hA5;

  // Status and padding bytes
  localparam logic [7:0] BYTE_STAT_A = 8'hAA;
  localparam logic [7:0] BYTE_STAT_B = 8'h55;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_PAD    = 8'hFF;

  // Device variants
  localparam logic [1:0] VAR_FIRST   = 2'd0;
  localparam logic [1:0] VAR_SECOND  = 2'd1;
  localparam logic [1:0] VAR_UNKNOWN = 2'd2;

  // CRC-16, reflected form
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_XOR  = 16'hFFFF;

  // Advance the reflected CRC-16 by one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Map a command byte to its phase; the second variant lacks the secure commands
  function automatic logic [3:0] command_phase(input logic [7:0] code, input logic [1:0] dv);
    logic [3:0] ph;
    unique case (code)
      OP_WRITE_SP:  ph = PH_WSP;
      OP_READ_SP:   ph = PH_RSP;
      OP_COPY_SP:   ph = PH_CSP;
      OP_READ_MEM:  ph = PH_RMEM;
      OP_LOAD_SEC:  ph = (dv == VAR_SECOND) ? PH_CMD : PH_LFS;
      OP_COMP_SEC:  ph = (dv == VAR_SECOND) ? PH_CMD : PH_CNS;
      OP_READ_PAGE: ph = (dv == VAR_SECOND) ? PH_CMD : PH_RAP;
      default:      ph = PH_CMD;
    endcase
    return ph;
  endfunction

endpackage

// ----- rtl/owtd_evt_if.sv -----
// ----------------------------------------------------------------------------
// owtd_evt_if: bus event channel
// Valid/ready channel carrying one bus event kind and its value byte.
// ----------------------------------------------------------------------------
interface owtd_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ----- rtl/owtd_res_if.sv -----
// ----------------------------------------------------------------------------
// owtd_res_if: decoded result channel
// Valid/ready channel carrying one decoded transaction report.
// ----------------------------------------------------------------------------
interface owtd_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [1:0]  detail;
  logic        ok;
  logic [23:0] payload;

  modport source (output valid, output kind, output detail, output ok, output payload,
                  input ready);
  modport sink   (input valid, input kind, input detail, input ok, input payload,
                  output ready);
endinterface

// ----- rtl/onewire_eeprom_transaction_decoder.sv -----
// ----------------------------------------------------------------------------
// onewire_eeprom_transaction_decoder: 1-Wire EEPROM bus transaction decoder
// Turns reset, ROM and data-byte events into command, address, data, CRC,
// authorization, MAC and status reports.
// ----------------------------------------------------------------------------
// Usage:
//   evt (sink): one bus event per handshake: cmd 0 reset/presence,
//     1 ROM with family code, 2 data byte, 3 ignored.
//   res (source): at most one report per event (kind/detail/ok/payload).
//   Each event is decoded in the cycle it is taken; its report appears in
//   the result register on the next cycle.
//   Throughput is one event per cycle while res does not stall: decode plus a
//   byte-wide CRC-16 step sit between the event input and the result register.
//   evt.ready is high while the result register is empty or being drained,
//   so a new event is taken even while a finished report is leaving.
//   If res stalls with a report held, evt.ready drops until it is taken.
//   Reset clears phase to idle, the byte position, the device variant, the
//   captured bytes, both CRC registers and the result valid flag.
//   Byte position saturates at POSITION_LIMIT.
// ----------------------------------------------------------------------------
module onewire_eeprom_transaction_decoder #(
  parameter int POSITION_LIMIT = 127
) (
  input  logic        clk,
  input  logic        rst,
  owtd_evt_if.sink    evt,
  owtd_res_if.source  res
);

  localparam int PW = $clog2(POSITION_LIMIT + 1);

  // Decoder state
  logic [3:0]    phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [1:0]    variant, variant_next;
  logic [7:0]    tlow, tlow_next;
  logic [7:0]    thigh, thigh_next;
  logic [7:0]    stat, stat_next;
  logic [7:0]    prev, prev_next;
  logic [15:0]   fcrc, fcrc_next;
  logic [15:0]   mcrc, mcrc_next;

  // Result register
  logic        out_valid;
  logic [3:0]  out_kind;
  logic [1:0]  out_detail;
  logic        out_ok;
  logic [23:0] out_payload;

  // Result of the current event
  logic        r_valid;
  logic [3:0]  r_kind;
  logic [1:0]  r_detail;
  logic        r_ok;
  logic [23:0] r_payload;

  // Data-byte datapath
  logic          acc;
  logic [PW-1:0] p;
  logic [3:0]    ph_sel;
  logic [PW-1:0] crc_lim;
  logic          feed_f, feed_m;
  logic [15:0]   fcrc_upd, mcrc_upd, fcrc_new, mcrc_new;
  logic [15:0]   recv;
  logic          fcrc_ok, mcrc_ok, is_stat;

  assign evt.ready = !out_valid || res.ready;
  assign acc       = evt.valid && evt.ready;

  // Advance the position, pick the phase and the CRC window
  assign p        = (pos < PW'(POSITION_LIMIT)) ? pos + 1'b1 : pos;
  assign ph_sel   = (phase == owtd_pkg::PH_CMD) ?
                    owtd_pkg::command_phase(evt.value, variant) : phase;
  assign crc_lim  = (ph_sel == owtd_pkg::PH_WSP) ? PW'(11) :
                    (ph_sel == owtd_pkg::PH_RSP) ? PW'(12) : PW'(36);
  assign feed_f   = (p <= crc_lim);
  assign feed_m   = (p >= PW'(39)) && (p <= PW'(58));
  assign fcrc_upd = owtd_pkg::crc_byte(fcrc, evt.value);
  assign mcrc_upd = owtd_pkg::crc_byte(mcrc, evt.value);
  assign fcrc_new = feed_f ? fcrc_upd : fcrc;
  assign mcrc_new = feed_m ? mcrc_upd : mcrc;
  assign recv     = {evt.value, prev};
  assign fcrc_ok  = ((fcrc_new ^ owtd_pkg::CRC_XOR) == recv);
  assign mcrc_ok  = ((mcrc_new ^ owtd_pkg::CRC_XOR) == recv);
  assign is_stat  = (evt.value == owtd_pkg::BYTE_STAT_A) ||
                    (evt.value == owtd_pkg::BYTE_STAT_B);

  // Decode one event into the next state and an optional report
  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    variant_next = variant;
    tlow_next    = tlow;
    thigh_next   = thigh;
    stat_next    = stat;
    prev_next    = prev;
    fcrc_next    = fcrc;
    mcrc_next    = mcrc;
    r_valid      = 1'b0;
    r_kind       = owtd_pkg::KIND_RESET;
    r_detail     = owtd_pkg::DET_NONE;
    r_ok         = 1'b0;
    r_payload    = 24'd0;
    if (acc) begin
      unique case (evt.cmd)
        owtd_pkg::CMD_RESET: begin
          pos_next   = '0;
          phase_next = owtd_pkg::PH_IDLE;
          fcrc_next  = 16'd0;
          mcrc_next  = 16'd0;
          r_valid    = 1'b1;
          r_kind     = owtd_pkg::KIND_RESET;
          r_ok       = (evt.value != owtd_pkg::BYTE_ZERO);
          r_payload  = {16'd0, evt.value};
        end
        owtd_pkg::CMD_ROM: begin
          if (evt.value == owtd_pkg::FAMILY_FIRST) begin
            variant_next = owtd_pkg::VAR_FIRST;
            r_detail     = owtd_pkg::DET_ROM_FIRST;
          end else if (evt.value == owtd_pkg::FAMILY_SECOND) begin
            variant_next = owtd_pkg::VAR_SECOND;
            r_detail     = owtd_pkg::DET_ROM_SECOND;
          end else begin
            variant_next = owtd_pkg::VAR_UNKNOWN;
            r_detail     = owtd_pkg::DET_ROM_UNKNOWN;
          end
          pos_next   = '0;
          phase_next = owtd_pkg::PH_CMD;
          fcrc_next  = 16'd0;
          mcrc_next  = 16'd0;
          r_valid    = 1'b1;
          r_kind     = owtd_pkg::KIND_ROM;
          r_payload  = {16'd0, evt.value};
        end
        owtd_pkg::CMD_DATA: begin
          pos_next   = p;
          prev_next  = evt.value;
          phase_next = ph_sel;
          fcrc_next  = fcrc_new;
          mcrc_next  = mcrc_new;
          if (p == PW'(2)) tlow_next  = evt.value;
          if (p == PW'(3)) thigh_next = evt.value;
          if (p == PW'(4)) stat_next  = evt.value;
          r_valid = 1'b1;
          unique case (phase)
            owtd_pkg::PH_CMD: begin
              r_kind    = (ph_sel == owtd_pkg::PH_CMD) ? owtd_pkg::KIND_WARNING :
                                                         owtd_pkg::KIND_COMMAND;
              r_payload = {16'd0, evt.value};
            end
            owtd_pkg::PH_WSP: begin
              if (p == PW'(3)) begin
                r_kind    = owtd_pkg::KIND_ADDRESS;
                r_payload = {8'd0, evt.value, tlow};
              end else if (p == PW'(11)) begin
                r_kind    = owtd_pkg::KIND_DATA;
                r_detail  = owtd_pkg::DET_DATA_BLOCK;
                r_payload = {16'd0, evt.value};
              end else if (p == PW'(13)) begin
                r_kind    = owtd_pkg::KIND_CRC;
                r_detail  = owtd_pkg::DET_CRC_FRAME;
                r_ok      = fcrc_ok;
                r_payload = {8'd0, recv};
              end else begin
                r_valid = 1'b0;
              end
            end
            owtd_pkg::PH_RSP: begin
              if (p == PW'(3)) begin
                r_kind    = owtd_pkg::KIND_ADDRESS;
                r_payload = {8'd0, evt.value, tlow};
              end else if (p == PW'(4)) begin
                r_kind    = owtd_pkg::KIND_ES;
                r_payload = {16'd0, evt.value};
              end else if (p == PW'(12)) begin
                r_kind    = owtd_pkg::KIND_DATA;
                r_detail  = owtd_pkg::DET_DATA_BLOCK;
                r_payload = {16'd0, evt.value};
              end else if (p == PW'(14)) begin
                r_kind    = owtd_pkg::KIND_CRC;
                r_detail  = owtd_pkg::DET_CRC_FRAME;
                r_ok      = fcrc_ok;
                r_payload = {8'd0, recv};
              end else begin
                r_valid = 1'b0;
              end
            end
            owtd_pkg::PH_CSP: begin
              if (p == PW'(4)) begin
                r_kind    = owtd_pkg::KIND_AUTH;
                r_payload = {stat_next, thigh_next, tlow_next};
              end else if (p == PW'(24)) begin
                r_kind    = owtd_pkg::KIND_MAC;
                r_payload = {16'd0, evt.value};
              end else if ((p > PW'(24)) && is_stat) begin
                r_kind    = owtd_pkg::KIND_STATUS;
                r_detail  = owtd_pkg::DET_ST_SUCCESS;
                r_payload = {16'd0, evt.value};
              end else if ((p > PW'(24)) && (evt.value == owtd_pkg::BYTE_ZERO)) begin
                r_kind    = owtd_pkg::KIND_STATUS;
                r_detail  = owtd_pkg::DET_ST_FAIL;
                r_payload = {16'd0, evt.value};
              end else begin
                r_valid = 1'b0;
              end
            end
            owtd_pkg::PH_RMEM: begin
              if (p == PW'(3)) begin
                r_kind    = owtd_pkg::KIND_ADDRESS;
                r_payload = {8'd0, evt.value, tlow};
              end else if (p > PW'(3)) begin
                r_kind    = owtd_pkg::KIND_DATA;
                r_detail  = owtd_pkg::DET_DATA_SINGLE;
                r_payload = {16'd0, evt.value};
              end else begin
                r_valid = 1'b0;
              end
            end
            owtd_pkg::PH_LFS: begin
              if (p == PW'(4)) begin
                r_kind    = owtd_pkg::KIND_AUTH;
                r_payload = {stat_next, thigh_next, tlow_next};
              end else if ((p > PW'(4)) && is_stat) begin
                r_kind    = owtd_pkg::KIND_STATUS;
                r_detail  = owtd_pkg::DET_ST_END;
                r_payload = {16'd0, evt.value};
              end else begin
                r_valid = 1'b0;
              end
            end
            owtd_pkg::PH_CNS: begin
              if (p == PW'(3)) begin
                r_kind    = owtd_pkg::KIND_ADDRESS;
                r_payload = {8'd0, evt.value, tlow};
              end else if ((p > PW'(3)) && is_stat) begin
                r_kind    = owtd_pkg::KIND_STATUS;
                r_detail  = owtd_pkg::DET_ST_END;
                r_payload = {16'd0, evt.value};
              end else begin
                r_valid = 1'b0;
              end
            end
            owtd_pkg::PH_RAP: begin
              if (p == PW'(3)) begin
                r_kind    = owtd_pkg::KIND_ADDRESS;
                r_payload = {8'd0, evt.value, tlow};
              end else if (p == PW'(35)) begin
                r_kind    = owtd_pkg::KIND_DATA;
                r_detail  = owtd_pkg::DET_DATA_BLOCK;
                r_payload = {16'd0, evt.value};
              end else if (p == PW'(36)) begin
                r_kind    = owtd_pkg::KIND_DATA;
                r_detail  = owtd_pkg::DET_DATA_PAD;
                r_ok      = (evt.value == owtd_pkg::BYTE_PAD);
                r_payload = {16'd0, evt.value};
              end else if (p == PW'(38)) begin
                r_kind    = owtd_pkg::KIND_CRC;
                r_detail  = owtd_pkg::DET_CRC_FRAME;
                r_ok      = fcrc_ok;
                r_payload = {8'd0, recv};
              end else if (p == PW'(58)) begin
                r_kind    = owtd_pkg::KIND_MAC;
                r_payload = {16'd0, evt.value};
              end else if (p == PW'(60)) begin
                r_kind    = owtd_pkg::KIND_CRC;
                r_detail  = owtd_pkg::DET_CRC_MAC;
                r_ok      = mcrc_ok;
                r_payload = {8'd0, recv};
              end else if ((p > PW'(60)) && is_stat) begin
                r_kind    = owtd_pkg::KIND_STATUS;
                r_detail  = owtd_pkg::DET_ST_DONE;
                r_payload = {16'd0, evt.value};
              end else begin
                r_valid = 1'b0;
              end
            end
            default: begin
              r_valid = 1'b0;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= owtd_pkg::PH_IDLE;
      pos     <= '0;
      variant <= owtd_pkg::VAR_FIRST;
      tlow    <= 8'd0;
      thigh   <= 8'd0;
      stat    <= 8'd0;
      prev    <= 8'd0;
      fcrc    <= 16'd0;
      mcrc    <= 16'd0;
    end else begin
      phase   <= phase_next;
      pos     <= pos_next;
      variant <= variant_next;
      tlow    <= tlow_next;
      thigh   <= thigh_next;
      stat    <= stat_next;
      prev    <= prev_next;
      fcrc    <= fcrc_next;
      mcrc    <= mcrc_next;
    end
  end

  // Load a report or drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && r_valid) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && r_valid) begin
      out_kind    <= r_kind;
      out_detail  <= r_detail;
      out_ok      <= r_ok;
      out_payload <= r_payload;
    end
  end

  assign res.valid   = out_valid;
  assign res.kind    = out_kind;
  assign res.detail  = out_detail;
  assign res.ok      = out_ok;
  assign res.payload = out_payload;

endmodule

// ----- rtl/owtd_checker.sv -----
// ----------------------------------------------------------------------------
// owtd_checker: port-level checks for the 1-Wire EEPROM decoder
// Watches both channels and flags broken reporting or flow control.
// ----------------------------------------------------------------------------
module owtd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic [7:0]  in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [1:0]  out_detail,
  input logic        out_ok,
  input logic [23:0] out_payload
);

  // Result channel comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A held report keeps its kind and payload until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(out_kind))
    else $error("stalled report changed");

  // Backpressure only while a report is stuck
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stuck report");

  // A reset transaction reports its presence byte on the next cycle
  a_reset_rep: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && in_ready && (in_cmd == owtd_pkg::CMD_RESET) |=>
      out_valid && (out_kind == owtd_pkg::KIND_RESET) &&
      (out_payload == {16'd0, $past(in_value)}) &&
      (out_ok == ($past(in_value) != owtd_pkg::BYTE_ZERO)))
    else $error("reset transaction misreported");

  // A ROM transaction reports the family variant
  a_rom_rep: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && in_ready && (in_cmd == owtd_pkg::CMD_ROM) |=>
      out_valid && (out_kind == owtd_pkg::KIND_ROM) &&
      ((out_detail == owtd_pkg::DET_ROM_FIRST) ==
       ($past(in_value) == owtd_pkg::FAMILY_FIRST)))
    else $error("ROM transaction misreported");

endmodule

bind onewire_eeprom_transaction_decoder owtd_checker u_owtd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (evt.valid),
  .in_ready    (evt.ready),
  .in_cmd      (evt.cmd),
  .in_value    (evt.value),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .out_kind    (res.kind),
  .out_detail  (res.detail),
  .out_ok      (res.ok),
  .out_payload (res.payload)
);
